// ===== hdl/mljs_pkg.sv =====
// Package for the multilevel preemptive job scheduler.
// Holds sizes, entry and item types and status codes; no dependencies.
`default_nettype none
package mljs_pkg;

  localparam int LEVELS      = 5;
  localparam int QUEUE_DEPTH = 64;
  localparam int LIDX_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LVL_W       = $clog2(LEVELS + 1);

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_RUNNING   = 3'd2,
    ST_COMPLETED = 3'd3,
    ST_IDLE_CPU  = 3'd4
  } status_t;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // queue entry: ordering key is {remaining, id}
  typedef struct packed {
    logic [11:0] rem;
    logic [7:0]  id;
  } entry_t;

  // per-level operation for one cycle
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t key;
  } lvl_op_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  job_id;
    logic [11:0] burst;
    logic [2:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  done_id;
    logic [31:0] done_dispatch_time;
    logic [31:0] done_end_time;
    logic        running_valid;
    logic [7:0]  running_id;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/mljs_cell.sv =====
// One cell of a sorted level queue: holds one entry and its valid bit.
// Depends on mljs_pkg.
`default_nettype none
module mljs_cell import mljs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire lvl_op_t op,
  input  wire logic    prev_valid,
  input  wire entry_t  prev_entry,
  input  wire logic    prev_gt,
  input  wire logic    next_valid,
  input  wire entry_t  next_entry,
  output logic         valid_o,
  output entry_t       entry_o,
  output logic         gt_o
);

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;

  // new key belongs at or before this cell
  assign gt_o = !valid_r || (entry_r > op.key);

  // pop shifts toward the head, insert shifts toward the tail
  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (op.pop) begin
      valid_nxt = next_valid;
      entry_nxt = next_entry;
    end else if (op.ins && gt_o) begin
      if (!prev_gt) begin
        valid_nxt = 1'b1;
        entry_nxt = op.key;
      end else begin
        valid_nxt = prev_valid;
        entry_nxt = prev_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign valid_o = valid_r;
  assign entry_o = entry_r;

endmodule
`default_nettype wire

// ===== hdl/mljs_level.sv =====
// One priority level: a chain of cells kept sorted, smallest at the head.
// Depends on mljs_pkg and mljs_cell.
`default_nettype none
module mljs_level import mljs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire lvl_op_t op,
  output logic         head_valid,
  output entry_t       head_entry,
  output logic         full
);

  logic   vld [QUEUE_DEPTH];
  entry_t ent [QUEUE_DEPTH];
  logic   gt  [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   pv, pg, nv;
    entry_t pe, ne;
    if (i == 0) begin : g_first
      assign pv = 1'b0;
      assign pe = '0;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pv = vld[i-1];
      assign pe = ent[i-1];
      assign pg = gt[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nv = 1'b0;
      assign ne = '0;
    end else begin : g_nlast
      assign nv = vld[i+1];
      assign ne = ent[i+1];
    end
    mljs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .prev_valid (pv),
      .prev_entry (pe),
      .prev_gt    (pg),
      .next_valid (nv),
      .next_entry (ne),
      .valid_o    (vld[i]),
      .entry_o    (ent[i]),
      .gt_o       (gt[i])
    );
  end

  assign head_valid = vld[0];
  assign head_entry = ent[0];
  assign full       = vld[QUEUE_DEPTH-1];

endmodule
`default_nettype wire

// ===== hdl/multilevel_preemptive_job_scheduler.sv =====
// Multilevel preemptive job scheduler, top level. Depends on mljs_pkg, mljs_level.
// Result: registered, valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; a tick that preempts
// also stalls the input (head pop, then the preempted job is filed into its level's cell chain).
// Reset (rst_n low, synchronous): queues empty, no job running, time zero.
`default_nettype none
module multilevel_preemptive_job_scheduler import mljs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_PUT  = 2'b10
  } fsm_t;

  fsm_t              state_r, state_nxt;
  logic              run_valid_r, run_valid_nxt;
  entry_t            run_entry_r, run_entry_nxt;
  logic [LVL_W-1:0]  run_lvl_r, run_lvl_nxt;
  logic [31:0]       disp_r, disp_nxt;
  logic [31:0]       time_r, time_nxt;
  logic [LIDX_W-1:0] put_lvl_r, put_lvl_nxt;
  entry_t            put_key_r, put_key_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  lvl_op_t ops [LEVELS];
  logic    hv  [LEVELS];
  entry_t  he  [LEVELS];
  logic    fl  [LEVELS];

  logic              accept;
  logic              best_any;
  logic [LIDX_W-1:0] best_l;
  entry_t            best_e;

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    mljs_level u_level (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (ops[l]),
      .head_valid (hv[l]),
      .head_entry (he[l]),
      .full       (fl[l])
    );
  end

  assign in_stall = (state_r != FSM_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // best waiting job: lowest non-empty level, its head
  always_comb begin
    best_any = 1'b0;
    best_l   = '0;
    best_e   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (hv[l]) begin
        best_any = 1'b1;
        best_l   = LIDX_W'(l);
        best_e   = he[l];
      end
    end
  end

  // item processing
  always_comb begin
    logic [2:0]        p;
    logic [LIDX_W-1:0] pi;
    logic [LVL_W-1:0]  bl1;
    logic [31:0]       tnew;
    entry_t            mine;
    logic              wins, room;
    state_nxt     = state_r;
    run_valid_nxt = run_valid_r;
    run_entry_nxt = run_entry_r;
    run_lvl_nxt   = run_lvl_r;
    disp_nxt      = disp_r;
    time_nxt      = time_r;
    put_lvl_nxt   = put_lvl_r;
    put_key_nxt   = put_key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    p    = in_data.priority_req;
    pi   = LIDX_W'(p - 3'd1);
    bl1  = LVL_W'(best_l) + LVL_W'(1);
    tnew = time_r + 32'd1;
    mine = run_entry_r;
    mine.rem = run_entry_r.rem - 12'd1;
    wins = 1'b0;
    room = 1'b0;
    for (int l = 0; l < LEVELS; l++) ops[l] = '0;

    if (state_r == FSM_PUT) begin
      ops[put_lvl_r].ins = 1'b1;
      ops[put_lvl_r].key = put_key_r;
      state_nxt = FSM_IDLE;
    end else if (accept) begin
      out_valid_nxt          = 1'b1;
      out_nxt                = '0;
      out_nxt.status         = ST_RUNNING;
      if (in_data.mode == MODE_INSERT) begin
        if (p >= 3'd1 && 32'(p) <= LEVELS && !fl[pi]) begin
          ops[pi].ins = 1'b1;
          ops[pi].key = {in_data.burst, in_data.job_id};
          out_nxt.status = ST_INSERTED;
        end else begin
          out_nxt.status = ST_DROPPED;
        end
      end else if (!run_valid_r) begin
        if (best_any) begin
          ops[best_l].pop = 1'b1;
          run_valid_nxt   = 1'b1;
          run_entry_nxt   = best_e;
          run_lvl_nxt     = bl1;
          disp_nxt        = time_r;
          out_nxt.status  = ST_RUNNING;
        end else begin
          run_entry_nxt  = '0;
          run_lvl_nxt    = '0;
          out_nxt.status = ST_IDLE_CPU;
        end
      end else begin
        time_nxt = tnew;
        if (run_entry_r.rem <= 12'd1) begin
          out_nxt.status             = ST_COMPLETED;
          out_nxt.done_id            = run_entry_r.id;
          out_nxt.done_dispatch_time = disp_r;
          out_nxt.done_end_time      = tnew;
          if (best_any) begin
            ops[best_l].pop = 1'b1;
            run_entry_nxt   = best_e;
            run_lvl_nxt     = bl1;
            disp_nxt        = tnew;
          end else begin
            run_valid_nxt = 1'b0;
            run_entry_nxt = '0;
            run_lvl_nxt   = '0;
          end
        end else begin
          run_entry_nxt = mine;
          if (run_lvl_r >= LVL_W'(1) && 32'(run_lvl_r) <= LEVELS && best_any) begin
            wins = (bl1 < run_lvl_r) || (bl1 == run_lvl_r && best_e < mine);
            room = (bl1 == run_lvl_r) || !fl[LIDX_W'(run_lvl_r - LVL_W'(1))];
            if (wins && room) begin
              ops[best_l].pop = 1'b1;
              run_entry_nxt   = best_e;
              run_lvl_nxt     = bl1;
              disp_nxt        = tnew;
              put_lvl_nxt     = LIDX_W'(run_lvl_r - LVL_W'(1));
              put_key_nxt     = mine;
              state_nxt       = FSM_PUT;
            end
          end
        end
      end
      out_nxt.running_valid = run_valid_nxt;
      out_nxt.running_id    = run_valid_nxt ? run_entry_nxt.id : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      run_valid_r <= 1'b0;
      run_entry_r <= '0;
      run_lvl_r   <= '0;
      disp_r      <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_valid_r <= run_valid_nxt;
      run_entry_r <= run_entry_nxt;
      run_lvl_r   <= run_lvl_nxt;
      disp_r      <= disp_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
    put_lvl_r <= put_lvl_nxt;
    put_key_r <= put_key_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
